[design/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define APM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("apm assertion failed");

// next-cycle implication, masked while in reset
`define APM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("apm assertion failed");

`endif

[design/apm_pkg.sv]
package apm_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int CHAR_W          = 8;
    localparam int CELL_W          = 5;
    localparam int LEN_W           = 5;
    localparam int POS_W           = 32;
    localparam int START_W         = 33;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int REG_CHARS       = 16;

    localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH,
        REG_CHARS_LOW,
        REG_CHARS_HIGH,
        REG_MAX_ERRORS
    } t_cfg_reg;

    // what one cell hands to the next
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] text_char;
        logic              first;
        logic [CELL_W-1:0] above;
        logic [CELL_W-1:0] diag;
        logic [CELL_W-1:0] sel;
    } t_apm_link;

    // restart value of row k+1, saturated
    function automatic logic [CELL_W-1:0] cell_init(input int k);
        if (k + 1 > int'(CELL_MAX)) begin
            return CELL_MAX;
        end
        return CELL_W'(k + 1);
    endfunction

endpackage

[design/apm_ifs.sv]
interface apm_in_if;
    import apm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              first;
    modport source (output valid, output text_char, output first, input ready);
    modport sink   (input valid, input text_char, input first, output ready);
endinterface

interface apm_out_if;
    import apm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      match;
    logic signed [START_W-1:0] start_position;
    logic [CELL_W-1:0]         distance;
    modport source (output valid, output match, output start_position, output distance,
                    input ready);
    modport sink   (input valid, input match, input start_position, input distance,
                    output ready);
endinterface

interface apm_cfg_if;
    import apm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/approximate_pattern_match_top.sv]
// an accepted word passes the row of cell registers, then the output register
// throughput: one word per cycle, set by the skewed row of PATTERN_MAX cells
// the whole row and the output register stall together when the result is not taken
// reset (synchronous, active low): no words in flight, column rows restart at i + 1,
// position 0, pattern length 1, pattern characters and error limit 0
module approximate_pattern_match_top #(
    parameter int PATTERN_MAX = apm_pkg::PATTERN_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apm_in_if.sink    i_in,
    apm_cfg_if.sink   i_cfg,
    apm_out_if.source o_out
);
    import apm_pkg::*;

    localparam int LW_RAW = $clog2(PATTERN_MAX + 1);
    localparam int LW     = (LW_RAW > LEN_W) ? LW_RAW : LEN_W;

    logic [LEN_W-1:0]          r_len;
    logic [CFG_DATA_W-1:0]     r_chars_lo;
    logic [CFG_DATA_W-1:0]     r_chars_hi;
    logic [LEN_W-1:0]          r_max_err;
    logic [2*CFG_DATA_W-1:0]   chars;
    logic [LW-1:0]             len_ext;
    logic [LW-1:0]             len_eff;
    logic                      adv;
    t_apm_link                 link [0:PATTERN_MAX];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_W'(1);
            r_chars_lo <= '0;
            r_chars_hi <= '0;
            r_max_err  <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_PATTERN_LENGTH: r_len      <= i_cfg.data[LEN_W-1:0];
                REG_CHARS_LOW:      r_chars_lo <= i_cfg.data;
                REG_CHARS_HIGH:     r_chars_hi <= i_cfg.data;
                REG_MAX_ERRORS:     r_max_err  <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign chars   = {r_chars_hi, r_chars_lo};
    assign len_ext = LW'(r_len);
    assign len_eff = (len_ext > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : len_ext;

    // row zero of the table is all zeros
    always_comb begin
        link[0].valid     = i_in.valid;
        link[0].text_char = i_in.text_char;
        link[0].first     = i_in.first;
        link[0].above     = '0;
        link[0].diag      = '0;
        link[0].sel       = '0;
    end

    assign i_in.ready = adv;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [CHAR_W-1:0] pat_char;
        logic              last;

        if (k < REG_CHARS) begin : g_char
            assign pat_char = chars[CHAR_W*k +: CHAR_W];
        end else begin : g_zero
            assign pat_char = '0;
        end

        assign last = (len_eff == LW'(k + 1));

        apm_cell #(
            .K (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_pat_char (pat_char),
            .i_last     (last),
            .i_link     (link[k]),
            .o_link     (link[k+1])
        );
    end

    apm_out #(
        .LW (LW)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_link       (link[PATTERN_MAX]),
        .i_len_eff    (len_eff),
        .i_max_errors (r_max_err),
        .o_adv        (adv),
        .o_out        (o_out)
    );

endmodule

[design/apm_cell.sv]
`include "assert_macros.svh"

module apm_cell #(
    parameter int K = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic [apm_pkg::CHAR_W-1:0] i_pat_char,
    input  logic                      i_last,
    input  apm_pkg::t_apm_link        i_link,
    output apm_pkg::t_apm_link        o_link
);
    import apm_pkg::*;

    localparam logic [CELL_W-1:0] INIT = cell_init(K);

    logic [CELL_W-1:0] r_value;
    t_apm_link         r_link;
    t_apm_link         n_link;
    logic [CELL_W-1:0] left;
    logic [CELL_W-1:0] m;
    logic [CELL_W-1:0] v;

    always_comb begin
        left = i_link.first ? INIT : r_value;
        m = (i_link.diag < i_link.above) ? i_link.diag : i_link.above;
        if (left < m) begin
            m = left;
        end
        if (i_pat_char == i_link.text_char) begin
            v = i_link.diag;
        end else if (m == CELL_MAX) begin
            v = CELL_MAX;
        end else begin
            v = m + CELL_W'(1);
        end
        n_link           = i_link;
        n_link.above     = v;
        n_link.diag      = left;
        n_link.sel       = i_last ? v : i_link.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value      <= INIT;
            r_link.valid <= 1'b0;
        end else if (i_adv) begin
            r_link <= n_link;
            if (i_link.valid) begin
                r_value <= v;
            end
        end
    end

    assign o_link = r_link;

    // a row never exceeds its own index plus one
    `APM_ASSERT_IMP(a_row_bound, i_clk, i_rst_n, 1'b1, r_value <= INIT)
    `APM_ASSERT_IMP(a_link_bound, i_clk, i_rst_n, r_link.valid,
                    (r_link.above <= INIT) && (r_link.diag <= INIT))

endmodule

[design/apm_out.sv]
`include "assert_macros.svh"

module apm_out #(
    parameter int LW = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  apm_pkg::t_apm_link         i_link,
    input  logic [LW-1:0]              i_len_eff,
    input  logic [apm_pkg::LEN_W-1:0]  i_max_errors,
    output logic                       o_adv,
    apm_out_if.source                  o_out
);
    import apm_pkg::*;

    logic                      r_valid;
    logic                      r_match;
    logic [START_W-1:0]        r_start;
    logic [CELL_W-1:0]         r_dist;
    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          n_pos;
    logic                      hit;
    logic [START_W-1:0]        start;

    assign o_adv = !r_valid || o_out.ready;

    always_comb begin
        if (i_link.first) begin
            n_pos = POS_W'(1);
        end else if (r_pos == POS_MAX) begin
            n_pos = POS_MAX;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
        hit   = LEN_W'(i_link.sel) <= i_max_errors;
        start = hit ? (START_W'(n_pos) - START_W'(i_len_eff) + START_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (o_adv) begin
            r_valid <= i_link.valid;
            if (i_link.valid) begin
                r_pos   <= n_pos;
                r_match <= hit;
                r_start <= start;
                r_dist  <= i_link.sel;
            end
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.match          = r_match;
    assign o_out.start_position = $signed(r_start);
    assign o_out.distance       = r_dist;

    // a new text restarts the position at one
    `APM_ASSERT_NXT(a_pos_restart, i_clk, i_rst_n,
                    i_link.valid && i_link.first && o_adv, r_pos == POS_W'(1))
    `APM_ASSERT_IMP(a_match_dist, i_clk, i_rst_n, r_valid && r_match,
                    LEN_W'(r_dist) <= i_max_errors)
    `APM_ASSERT_IMP(a_nomatch_start, i_clk, i_rst_n, r_valid && !r_match,
                    r_start == '0)

endmodule

[dv/tb_approximate_pattern_match_top.sv]
module tb_approximate_pattern_match_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apm_pkg::*;

    localparam int PATTERN_MAX    = PATTERN_MAX_DEF;
    localparam int LATENCY        = PATTERN_MAX + 1;
    localparam int RANDOM_WORDS   = 550;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic               match;
        logic [START_W-1:0] start_position;
        logic [CELL_W-1:0]  distance;
    } t_match_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    apm_in_if  in_if ();
    apm_cfg_if cfg_if ();
    apm_out_if out_if ();

    approximate_pattern_match_top #(
        .PATTERN_MAX (PATTERN_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block's registers and column
    logic [LEN_W-1:0]      pattern_len_q;
    logic [CFG_DATA_W-1:0] chars_low_q;
    logic [CFG_DATA_W-1:0] chars_high_q;
    logic [LEN_W-1:0]      error_limit_q;
    logic [CELL_W-1:0]     column_q [PATTERN_MAX];
    logic [POS_W-1:0]      position_q;

    t_match_result pending_results [$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            random_sent    = 0;
    logic          in_gapless     = 1'b0;
    logic          out_gapless    = 1'b0;
    logic          text_restart   = 1'b0;

    function automatic logic [CHAR_W-1:0] pattern_byte(input int k);
        if (k < 8) begin
            return chars_low_q[8*k +: 8];
        end
        if (k < REG_CHARS) begin
            return chars_high_q[8*(k-8) +: 8];
        end
        return '0;
    endfunction

    function automatic void restart_text();
        for (int k = 0; k < PATTERN_MAX; k++) begin
            column_q[k] = (k + 1 > int'(CELL_MAX)) ? CELL_MAX : CELL_W'(k + 1);
        end
        position_q = '0;
    endfunction

    // one column update of the edit-distance table for a text byte
    function automatic t_match_result advance_column(input logic [CHAR_W-1:0] c,
                                                     input logic f);
        t_match_result    r;
        logic [CELL_W:0]  diag;
        logic [CELL_W:0]  above;
        logic [CELL_W:0]  left;
        logic [CELL_W:0]  m;
        logic [CELL_W:0]  v;
        int               len;
        logic [CELL_W-1:0] pat_dist;
        if (f) begin
            restart_text();
        end
        if (position_q != POS_MAX) begin
            position_q = position_q + 1'b1;
        end
        diag  = '0;
        above = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            left = {1'b0, column_q[k]};
            if (pattern_byte(k) == c) begin
                v = diag;
            end else begin
                m = (diag < above) ? diag : above;
                if (left < m) begin
                    m = left;
                end
                v = m + 1'b1;
                if (v > {1'b0, CELL_MAX}) begin
                    v = {1'b0, CELL_MAX};
                end
            end
            diag        = left;
            column_q[k] = v[CELL_W-1:0];
            above       = v;
        end
        len      = (int'(pattern_len_q) > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len_q);
        pat_dist = (len == 0) ? '0 : column_q[len-1];
        r.match          = (pat_dist <= error_limit_q);
        r.start_position = r.match ? ({1'b0, position_q} - START_W'(len) + START_W'(1)) : '0;
        r.distance       = pat_dist;
        return r;
    endfunction

    // ---------------- stimulus primitives ----------------

    task automatic send_word(input logic [CHAR_W-1:0] c, input logic f);
        int gap;
        gap = in_gapless ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.text_char <= c;
        in_if.first     <= f;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results.push_back(advance_column(c, f));
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_PATTERN_LENGTH: pattern_len_q = value[LEN_W-1:0];
            REG_CHARS_LOW:      chars_low_q   = value;
            REG_CHARS_HIGH:     chars_high_q  = value;
            REG_MAX_ERRORS:     error_limit_q = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // registers change only with nothing in flight
    task automatic configure(input logic [LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] low,
                             input logic [CFG_DATA_W-1:0] high,
                             input logic [LEN_W-1:0] limit);
        logic [CFG_DATA_W-1:0] junk;
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        junk = {$urandom, $urandom};
        write_reg(REG_PATTERN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
        write_reg(REG_CHARS_LOW, low);
        write_reg(REG_CHARS_HIGH, high);
        junk = {$urandom, $urandom};
        write_reg(REG_MAX_ERRORS, {junk[CFG_DATA_W-1:LEN_W], limit});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_text_byte(input logic [CHAR_W-1:0] c);
        logic f;
        f            = text_restart || ($urandom_range(0, 39) == 0);
        text_restart = 1'b0;
        send_word(c, f);
        random_sent++;
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        // length 1, pattern byte 0, no errors allowed
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
    endtask

    task automatic test_exact_match();
        configure(5'd4, 64'h0000_0000_6463_6261, 64'h0, 5'd0);
        send_word(8'h78, 1'b1);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'h63, 1'b0);
        send_word(8'h64, 1'b0);
    endtask

    task automatic test_empty_pattern();
        configure(5'd0, 64'h0123_4567_89AB_CDEF, 64'h0, 5'd0);
        send_word(8'h5A, 1'b1);
        send_word(8'h00, 1'b0);
    endtask

    task automatic test_long_pattern();
        // length beyond the row count, start positions go negative
        configure(5'd31, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 5'd31);
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        configure(5'd16, 64'h0, 64'h0, 5'd17);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task automatic test_length_change();
        // column carries on without a restart
        configure(5'd8, 64'h6161_6161_6161_6161, 64'h0, 5'd2);
        send_word(8'h00, 1'b0);
        send_word(8'h61, 1'b0);
    endtask

    task automatic test_random_text();
        logic [CHAR_W-1:0]     pat [REG_CHARS];
        logic [CHAR_W-1:0]     alpha [REG_CHARS];
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        logic [LEN_W-1:0]      limit;
        int                    alpha_n;
        int                    len;
        int                    eff;
        int                    phase_end;
        int                    r;
        int                    n;
        while (random_sent < RANDOM_WORDS) begin
            in_gapless  = ($urandom_range(0, 3) == 0);
            out_gapless = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                for (int k = 0; k < REG_CHARS; k++) begin
                    pat[k]   = CHAR_W'($urandom);
                    alpha[k] = pat[k];
                end
                alpha_n = REG_CHARS;
            end else begin
                // few distinct bytes so that the text keeps hitting the pattern
                alpha_n = $urandom_range(2, 4);
                for (int k = 0; k < alpha_n; k++) begin
                    alpha[k] = CHAR_W'($urandom);
                end
                for (int k = 0; k < REG_CHARS; k++) begin
                    pat[k] = alpha[$urandom_range(0, alpha_n - 1)];
                end
            end
            for (int k = 0; k < 8; k++) begin
                low[8*k +: 8]  = pat[k];
                high[8*k +: 8] = pat[k+8];
            end
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(PATTERN_MAX + 1, 31);
                default: len = $urandom_range(1, PATTERN_MAX);
            endcase
            eff   = (len > PATTERN_MAX) ? PATTERN_MAX : len;
            limit = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 31))
                                                : LEN_W'($urandom_range(0, 3));
            configure(LEN_W'(len), low, high, limit);
            text_restart = ($urandom_range(0, 2) != 0);
            phase_end    = random_sent + $urandom_range(30, 60);
            while (random_sent < phase_end) begin
                if (eff > 0 && $urandom_range(0, 9) < 7) begin
                    // copy of the pattern with a few edits
                    for (int k = 0; k < eff; k++) begin
                        r = $urandom_range(0, 9);
                        if (r == 0) begin
                            continue;
                        end
                        if (r == 2) begin
                            send_text_byte(alpha[$urandom_range(0, alpha_n - 1)]);
                        end
                        send_text_byte((r == 1) ? alpha[$urandom_range(0, alpha_n - 1)]
                                                : pat[k]);
                    end
                end else begin
                    n = $urandom_range(1, 5);
                    repeat (n) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_text_byte(CHAR_W'($urandom_range(0, 255)));
                        end else begin
                            send_text_byte(alpha[$urandom_range(0, alpha_n - 1)]);
                        end
                    end
                end
            end
        end
    endtask

    // ---------------- result side ----------------

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = out_gapless ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    always @(posedge i_clk) begin
        t_match_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word match %0b start %0d distance %0d",
                         $time, out_if.match, out_if.start_position, out_if.distance);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_if.match !== exp_r.match) begin
                    $display("%0t: match expected %0b actual %0b",
                             $time, exp_r.match, out_if.match);
                    mismatch_count++;
                end
                if (out_if.start_position !== exp_r.start_position) begin
                    $display("%0t: start_position expected %0d actual %0d", $time,
                             $signed(exp_r.start_position), out_if.start_position);
                    mismatch_count++;
                end
                if (out_if.distance !== exp_r.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, exp_r.distance, out_if.distance);
                    mismatch_count++;
                end
            end
        end
    end

    // stop a hung run
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.text_char = '0;
        in_if.first     = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_PATTERN_LENGTH;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        pattern_len_q   = LEN_W'(1);
        chars_low_q     = '0;
        chars_high_q    = '0;
        error_limit_q   = '0;
        restart_text();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_exact_match();
        test_empty_pattern();
        test_long_pattern();
        test_length_change();
        test_random_text();

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/apm_pkg.sv
design/apm_ifs.sv
design/apm_cell.sv
design/apm_out.sv
design/approximate_pattern_match_top.sv
dv/tb_approximate_pattern_match_top.sv
